### rtl/core/bmsp_pkg.sv
// bmsp_pkg: shared types and constants for the binary mesh stream parser
// holds parser phases, result kinds, error codes and the queue entry format
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bmsp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic [WORD_W-1:0] CORNERS_PER_FACE = 32'd3;
  localparam int unsigned INDEX_W = 16;

  typedef enum logic [2:0] {
    PH_VCOUNT = 3'd0,
    PH_VERTS  = 3'd1,
    PH_FCOUNT = 3'd2,
    PH_FACES  = 3'd3,
    PH_NCOUNT = 3'd4,
    PH_NORMS  = 3'd5,
    PH_TAIL   = 3'd6,
    PH_DROP   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_VERTEX = 3'd0,
    KIND_FACE   = 3'd1,
    KIND_NORMAL = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_ZERO_VERTS = 2'd0,
    ERR_SHORT      = 2'd1,
    ERR_ZERO_FACES = 2'd2,
    ERR_NOT_TRI    = 2'd3
  } err_t;

  // one result transaction
  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] index;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    err_t              err;
  } result_t;

  // all results caused by one input word: a record, then done or error
  typedef struct packed {
    logic    has_a;
    result_t a;
    logic    has_b;
    result_t b;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/bmsp_front.sv
// bmsp_front: accepts mesh words, tracks the layout and builds result entries
// depends on bmsp_pkg; pushes into bmsp_queue
`timescale 1ns / 1ps
`default_nettype none

module bmsp_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [31:0]               in_data_word,
  input  wire logic                      in_final_word,
  input  wire logic                      q_full,
  output logic                           push,
  output bmsp_pkg::entry_t               push_entry
);
  import bmsp_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [WORD_W-1:0] vertex_total_r, vertex_total_nxt;
  logic [WORD_W-1:0] face_total_r, face_total_nxt;
  logic [WORD_W-1:0] normal_total_r, normal_total_nxt;
  logic [WORD_W-1:0] record_counter_r, record_counter_nxt;
  logic [1:0]        word_in_record_r, word_in_record_nxt;
  logic [WORD_W-1:0] held0_r, held0_nxt;
  logic [WORD_W-1:0] held1_r, held1_nxt;

  logic              accept;
  logic [WORD_W-1:0] cnt_inc;
  logic [WORD_W-1:0] word_idx;
  logic [WORD_W-1:0] normal_cap;
  logic              dec_err;
  err_t              dec_code;
  logic              dec_rec;
  kind_t             dec_kind;
  phase_t            step_phase;
  logic              tail_done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = record_counter_r + 32'd1;
  assign word_idx = {{(WORD_W-INDEX_W){1'b0}}, in_data_word[INDEX_W-1:0]};
  assign normal_cap = (in_data_word < vertex_total_r) ? in_data_word : vertex_total_r;
  assign tail_done  = (step_phase == PH_NCOUNT) || (step_phase == PH_NORMS) ||
                      (step_phase == PH_TAIL);

  // decode the word against the current phase
  always_comb begin
    dec_err    = 1'b0;
    dec_code   = ERR_ZERO_VERTS;
    dec_rec    = 1'b0;
    dec_kind   = KIND_VERTEX;
    step_phase = phase_r;
    case (phase_r)
      PH_VCOUNT: begin
        if (in_data_word == '0) begin
          dec_err  = 1'b1;
          dec_code = ERR_ZERO_VERTS;
        end else begin
          step_phase = PH_VERTS;
        end
      end
      PH_VERTS: begin
        if (word_in_record_r == 2'd2) begin
          dec_rec  = 1'b1;
          dec_kind = KIND_VERTEX;
          if (cnt_inc == vertex_total_r) step_phase = PH_FCOUNT;
        end
      end
      PH_FCOUNT: begin
        if (in_data_word == '0) begin
          dec_err  = 1'b1;
          dec_code = ERR_ZERO_FACES;
        end else begin
          step_phase = PH_FACES;
        end
      end
      PH_FACES: begin
        if (word_in_record_r == 2'd0) begin
          if (in_data_word != CORNERS_PER_FACE) begin
            dec_err  = 1'b1;
            dec_code = ERR_NOT_TRI;
          end
        end else if (word_in_record_r == 2'd3) begin
          dec_rec  = 1'b1;
          dec_kind = KIND_FACE;
          if (cnt_inc == face_total_r) step_phase = PH_NCOUNT;
        end
      end
      PH_NCOUNT: begin
        step_phase = (normal_cap == '0) ? PH_TAIL : PH_NORMS;
      end
      PH_NORMS: begin
        if (word_in_record_r == 2'd2) begin
          dec_rec  = 1'b1;
          dec_kind = KIND_NORMAL;
          if (cnt_inc == normal_total_r) step_phase = PH_TAIL;
        end
      end
      PH_TAIL: begin
        step_phase = PH_TAIL;
      end
      default: begin
        step_phase = PH_DROP;
      end
    endcase
  end

  // next state of the parser
  always_comb begin
    phase_nxt          = step_phase;
    vertex_total_nxt   = vertex_total_r;
    face_total_nxt     = face_total_r;
    normal_total_nxt   = normal_total_r;
    record_counter_nxt = record_counter_r;
    word_in_record_nxt = word_in_record_r;
    held0_nxt          = held0_r;
    held1_nxt          = held1_r;

    case (phase_r)
      PH_VCOUNT: begin
        if (!dec_err) begin
          vertex_total_nxt   = in_data_word;
          record_counter_nxt = '0;
          word_in_record_nxt = 2'd0;
        end
      end
      PH_VERTS, PH_NORMS: begin
        if (dec_rec) begin
          word_in_record_nxt = 2'd0;
          record_counter_nxt = cnt_inc;
        end else begin
          if (word_in_record_r == 2'd0) held0_nxt = in_data_word;
          else held1_nxt = in_data_word;
          word_in_record_nxt = word_in_record_r + 2'd1;
        end
      end
      PH_FCOUNT: begin
        if (!dec_err) begin
          face_total_nxt     = in_data_word;
          record_counter_nxt = '0;
          word_in_record_nxt = 2'd0;
        end
      end
      PH_FACES: begin
        if (dec_rec) begin
          word_in_record_nxt = 2'd0;
          record_counter_nxt = cnt_inc;
        end else if (!dec_err) begin
          if (word_in_record_r == 2'd1) held0_nxt = word_idx;
          if (word_in_record_r == 2'd2) held1_nxt = word_idx;
          word_in_record_nxt = word_in_record_r + 2'd1;
        end
      end
      PH_NCOUNT: begin
        normal_total_nxt   = normal_cap;
        record_counter_nxt = '0;
        word_in_record_nxt = 2'd0;
      end
      default: begin
        word_in_record_nxt = word_in_record_r;
      end
    endcase

    // errors move to dropping, a final word rearms for the next mesh
    if (dec_err && !in_final_word) begin
      phase_nxt = PH_DROP;
    end
    if (in_final_word) begin
      phase_nxt          = PH_VCOUNT;
      vertex_total_nxt   = '0;
      face_total_nxt     = '0;
      normal_total_nxt   = '0;
      record_counter_nxt = '0;
      word_in_record_nxt = 2'd0;
    end
  end

  // entry built from this word
  always_comb begin
    push_entry       = '0;
    push_entry.a.kind  = dec_kind;
    push_entry.a.index = record_counter_r;
    push_entry.a.x     = held0_r;
    push_entry.a.y     = held1_r;
    push_entry.a.z     = (dec_kind == KIND_FACE) ? word_idx : in_data_word;
    push_entry.a.err   = ERR_ZERO_VERTS;
    push_entry.has_a   = dec_rec;
    push_entry.b.kind  = KIND_ERROR;
    push_entry.b.err   = dec_code;
    push_entry.has_b   = 1'b0;
    if (phase_r != PH_DROP) begin
      if (dec_err) begin
        push_entry.has_b = 1'b1;
      end else if (in_final_word) begin
        push_entry.has_b = 1'b1;
        if (tail_done) begin
          push_entry.b.kind = KIND_DONE;
          push_entry.b.x    = vertex_total_r;
          push_entry.b.y    = face_total_r;
          push_entry.b.err  = ERR_ZERO_VERTS;
        end else begin
          push_entry.b.err = ERR_SHORT;
        end
      end
    end
    push = accept && (push_entry.has_a || push_entry.has_b);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_VCOUNT;
      vertex_total_r   <= '0;
      face_total_r     <= '0;
      normal_total_r   <= '0;
      record_counter_r <= '0;
      word_in_record_r <= 2'd0;
    end else if (accept) begin
      phase_r          <= phase_nxt;
      vertex_total_r   <= vertex_total_nxt;
      face_total_r     <= face_total_nxt;
      normal_total_r   <= normal_total_nxt;
      record_counter_r <= record_counter_nxt;
      word_in_record_r <= word_in_record_nxt;
    end
  end

  // held words, always written before they are read
  always_ff @(posedge clk) begin
    if (accept) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bmsp_queue.sv
// bmsp_queue: short first-in first-out queue of result entries
// depends on bmsp_pkg; sits between bmsp_front and bmsp_back
`timescale 1ns / 1ps
`default_nettype none

module bmsp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bmsp_pkg::entry_t push_entry,
  input  wire logic             pop,
  output bmsp_pkg::entry_t      head_entry,
  output logic                  not_empty,
  output logic                  full
);
  import bmsp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head_entry = slot_r[rd_ptr_r];
  assign not_empty  = (count_r != '0);
  assign full       = (count_r == FULL_CNT);

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

`default_nettype wire

### rtl/core/bmsp_back.sv
// bmsp_back: drains queue entries into the result channel, one result a cycle
// while out_ready holds; depends on bmsp_pkg; reads the head of bmsp_queue
`timescale 1ns / 1ps
`default_nettype none

module bmsp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bmsp_pkg::entry_t head_entry,
  input  wire logic             not_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            out_record_kind,
  output logic [31:0]           out_record_index,
  output logic [31:0]           out_value_x,
  output logic [31:0]           out_value_y,
  output logic [31:0]           out_value_z,
  output logic [1:0]            out_error_code
);
  import bmsp_pkg::*;

  logic    out_valid_r;
  result_t out_res_r;
  logic    second_r, second_nxt;
  logic    load;
  result_t pick;

  // output register frees when empty or taken
  assign load = not_empty && (!out_valid_r || out_ready);

  // choose the record first, then the done or error result
  always_comb begin
    pick       = head_entry.a;
    pop        = 1'b0;
    second_nxt = second_r;
    if (load) begin
      if (head_entry.has_a && !second_r) begin
        pick = head_entry.a;
        if (head_entry.has_b) begin
          second_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        pick       = head_entry.b;
        pop        = 1'b1;
        second_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      second_r <= second_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res_r <= pick;
  end

  assign out_valid        = out_valid_r;
  assign out_record_kind  = out_res_r.kind;
  assign out_record_index = out_res_r.index;
  assign out_value_x      = out_res_r.x;
  assign out_value_y      = out_res_r.y;
  assign out_value_z      = out_res_r.z;
  assign out_error_code   = out_res_r.err;

endmodule

`default_nettype wire

### rtl/core/binary_mesh_stream_parser.sv
// binary_mesh_stream_parser: top level of the binary triangle mesh parser
// depends on bmsp_pkg, bmsp_front, bmsp_queue and bmsp_back
//
// usage: feed one 32-bit mesh word per input transaction (in_valid/in_ready),
// with in_final_word set on the last word of each mesh. results leave on the
// out_ channel: vertex, face and normal records, then done, or an error.
// throughput: one input word per cycle while the queue has room; the result
// register emits one result per cycle while out_ready holds, so a word that
// completes a record and also ends the mesh gives the back end two results.
// path: an accepted word writes its entry into the queue, and the output
// register loads it from the queue head once free; a second result of the
// same word follows the first, from the same queue entry.
// stalls: the front keeps taking words while the queue has room, so up to
// QUEUE_DEPTH entries plus the output register absorb a stalled receiver;
// in_ready drops only when the queue is full.
// reset: synchronous active-low rst_n empties the queue and output register
// and sets the parser to expect the vertex count of a new mesh.
`timescale 1ns / 1ps
`default_nettype none

module binary_mesh_stream_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic        in_final_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_record_kind,
  output logic [31:0]      out_record_index,
  output logic [31:0]      out_value_x,
  output logic [31:0]      out_value_y,
  output logic [31:0]      out_value_z,
  output logic [1:0]       out_error_code
);
  import bmsp_pkg::*;

  logic   q_full;
  logic   q_not_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head_entry;

  // front: layout tracking
  bmsp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_final_word (in_final_word),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  // queue between front and back
  bmsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  // back: result emission
  bmsp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_entry       (head_entry),
    .not_empty        (q_not_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_record_kind  (out_record_kind),
    .out_record_index (out_record_index),
    .out_value_x      (out_value_x),
    .out_value_y      (out_value_y),
    .out_value_z      (out_value_z),
    .out_error_code   (out_error_code)
  );

endmodule

`default_nettype wire
